[hw/rtl/mrf_pkg.sv]
// Shared constants and codes for the MRF ICM label segmenter.
package mrf_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int MAX_CLASSES = 8;
    localparam int STORE_SIZE  = MAX_ROWS * MAX_COLS;

    localparam int ADDR_W = $clog2(STORE_SIZE);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int DIM_W  = 7;
    localparam int CCNT_W = 4;
    localparam int LAB_W  = 3;
    localparam int PIX_W  = 8;
    localparam int Q_W    = 16;
    localparam int E_W    = 48;
    localparam int MUL_A_W = 32;
    localparam int MUL_P_W = MUL_A_W + Q_W;
    localparam int PAIR_W = Q_W + 6;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [2:0] REG_ROWS   = 3'd0;
    localparam logic [2:0] REG_COLS   = 3'd1;
    localparam logic [2:0] REG_CLASS  = 3'd2;
    localparam logic [2:0] REG_BETA   = 3'd3;
    localparam logic [2:0] REG_THRESH = 3'd4;
    localparam logic [2:0] REG_PASSES = 3'd5;

endpackage

[hw/rtl/mrf_icm_label_segmenter.sv]
// Top level: MRF ICM segmenter with pixel/label memories and a pixel sequencer.
// Load and write requests finish when accepted; a read request passes through the label
// memory read register and the RDLAB state to its result. A run walks the image once for
// initial labels, then alternates an energy sweep and an ICM sweep; each sweep is closed
// by a pass-end state, and all of them share the one multiplier.
// Async active-low reset clears control state and loads configuration register defaults.
module mrf_icm_label_segmenter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // index[11:0], pixel_value[19:12], class_mean[35:20], class_scale[51:36],
    // class_offset[67:52], zero fill above
    input  logic [mrf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // label[2:0], passes[10:3], converged[11], energy[59:12], zero fill above
    output logic [mrf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic        m_axis_tuser
);
    import mrf_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RDLAB   = 4'd1;
    localparam logic [3:0] S_FETCH   = 4'd2;
    localparam logic [3:0] S_SQ      = 4'd3;
    localparam logic [3:0] S_PROD    = 4'd4;
    localparam logic [3:0] S_EVAL    = 4'd5;
    localparam logic [3:0] S_PIXEND  = 4'd6;
    localparam logic [3:0] S_PASSEND = 4'd7;

    localparam logic [1:0] PH_ML    = 2'd0;
    localparam logic [1:0] PH_TOTAL = 2'd1;
    localparam logic [1:0] PH_ICM   = 2'd2;

    // request fields
    logic [1:0]        in_op;
    logic [11:0]       in_index;
    logic [PIX_W-1:0]  in_pixel;
    logic [Q_W-1:0]    in_mean;
    logic [Q_W-1:0]    in_scale;
    logic [Q_W-1:0]    in_offset;

    assign in_op     = s_axis_tuser;
    assign in_index  = s_axis_tdata[11:0];
    assign in_pixel  = s_axis_tdata[19:12];
    assign in_mean   = s_axis_tdata[35:20];
    assign in_scale  = s_axis_tdata[51:36];
    assign in_offset = s_axis_tdata[67:52];

    // configuration
    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic [CCNT_W-1:0] ccount_reg;
    logic [Q_W-1:0]    beta_reg;
    logic [31:0]       thr_reg;
    logic [7:0]        maxp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= DIM_W'(64);
            cols_reg   <= DIM_W'(64);
            ccount_reg <= CCNT_W'(2);
            beta_reg   <= Q_W'(256);
            thr_reg    <= '0;
            maxp_reg   <= 8'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS:   rows_reg   <= cfg_data[DIM_W-1:0];
                REG_COLS:   cols_reg   <= cfg_data[DIM_W-1:0];
                REG_CLASS:  ccount_reg <= cfg_data[CCNT_W-1:0];
                REG_BETA:   beta_reg   <= cfg_data[Q_W-1:0];
                REG_THRESH: thr_reg    <= cfg_data;
                REG_PASSES: maxp_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clamped geometry and limits
    logic [DIM_W-1:0]  rows_eff, cols_eff;
    logic [CCNT_W-1:0] ncls_eff;
    logic [7:0]        limit_eff;

    always_comb
    begin
        rows_eff  = (rows_reg == '0) ? DIM_W'(1)
                  : ((rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_reg);
        cols_eff  = (cols_reg == '0) ? DIM_W'(1)
                  : ((cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_reg);
        ncls_eff  = (ccount_reg == '0) ? CCNT_W'(1)
                  : ((ccount_reg > CCNT_W'(MAX_CLASSES)) ? CCNT_W'(MAX_CLASSES) : ccount_reg);
        limit_eff = (maxp_reg == '0) ? 8'd1 : maxp_reg;
    end

    // class tables
    logic [Q_W-1:0] mean_tab  [MAX_CLASSES];
    logic [Q_W-1:0] scale_tab [MAX_CLASSES];
    logic [Q_W-1:0] off_tab   [MAX_CLASSES];

    logic in_accept;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (in_accept && in_op == OP_LOAD && 13'(in_index) < 13'(MAX_CLASSES))
        begin
            mean_tab[in_index[CLS_W-1:0]]  <= in_mean;
            scale_tab[in_index[CLS_W-1:0]] <= in_scale;
            off_tab[in_index[CLS_W-1:0]]   <= in_offset;
        end
    end

    // sequencer registers
    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic              first_tot_reg, first_tot_next;
    logic              first_eval_reg, first_eval_next;
    logic [2:0]        fj_reg, fj_next;
    logic [ROW_W-1:0]  r_reg, r_next;
    logic [COL_W-1:0]  c_reg, c_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic [LAB_W-1:0]  lab_reg, lab_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [LAB_W-1:0]  nb_reg [5];
    logic [LAB_W-1:0]  nb_next [5];
    logic signed [E_W-1:0] best_reg, best_next;
    logic signed [E_W-1:0] acc_reg, acc_next;
    logic signed [E_W-1:0] prev_reg, prev_next;
    logic [7:0]        passes_reg, passes_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [LAB_W-1:0]  out_label_reg, out_label_next;
    logic [7:0]        out_passes_reg, out_passes_next;
    logic              out_conv_reg, out_conv_next;
    logic [E_W-1:0]    out_energy_reg, out_energy_next;

    // memories
    logic [PIX_W-1:0] pix_mem [STORE_SIZE];
    logic [LAB_W-1:0] lab_mem [STORE_SIZE];
    logic [PIX_W-1:0] pix_rd_reg;
    logic [LAB_W-1:0] lab_rd_reg;
    logic [ADDR_W-1:0] pix_raddr, lab_raddr, cur_addr;
    logic              lab_we;

    assign cur_addr = ADDR_W'(32'(r_reg) * MAX_COLS + 32'(c_reg));

    always_comb
    begin
        pix_raddr = cur_addr;
        lab_raddr = cur_addr;
        if (state_reg == S_IDLE)
        begin
            lab_raddr = in_index[ADDR_W-1:0];
        end
        else
        begin
            case (fj_reg)
                3'd1:    lab_raddr = cur_addr - ADDR_W'(MAX_COLS);
                3'd2:    lab_raddr = cur_addr + ADDR_W'(MAX_COLS);
                3'd3:    lab_raddr = cur_addr - ADDR_W'(1);
                3'd4:    lab_raddr = cur_addr + ADDR_W'(1);
                default: lab_raddr = cur_addr;
            endcase
        end
    end

    assign lab_we = (state_reg == S_PIXEND) && (phase_reg != PH_TOTAL);

    always_ff @(posedge clk)
    begin
        if (in_accept && in_op == OP_WRITE && 13'(in_index) < 13'(STORE_SIZE))
        begin
            pix_mem[in_index[ADDR_W-1:0]] <= in_pixel;
        end
        pix_rd_reg <= pix_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[cur_addr] <= lab_reg;
        end
        lab_rd_reg <= lab_mem[lab_raddr];
    end

    // shared multiplier: |d|*|d| then square*scale
    logic signed [Q_W+1:0] diff;
    logic [Q_W-1:0]        diff_abs;
    logic                  mul_en;
    logic [MUL_A_W-1:0]    mul_a;
    logic [Q_W-1:0]        mul_b;
    logic [MUL_P_W-1:0]    mul_p;

    assign diff     = $signed({2'b00, pix_reg, 8'b0}) - $signed({2'b00, mean_tab[cls_reg]});
    assign diff_abs = diff[Q_W+1] ? Q_W'(-diff) : diff[Q_W-1:0];
    assign mul_en   = (state_reg == S_SQ) || (state_reg == S_PROD);
    assign mul_a    = (state_reg == S_SQ) ? MUL_A_W'(diff_abs) : mul_p[MUL_A_W-1:0];
    assign mul_b    = (state_reg == S_SQ) ? diff_abs : scale_tab[cls_reg];

    mrf_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // local energy of class cls_reg
    logic              v_up, v_dn, v_lf, v_rt;
    logic [2:0]        n_valid, n_same;
    logic signed [5:0] pair_mult;
    logic signed [PAIR_W-1:0] pair_term;
    logic signed [E_W-1:0]    e_val;
    logic [Q_W-1:0]    off_cur;

    always_comb
    begin
        v_up = (phase_reg == PH_ICM) && (r_reg != '0);
        v_lf = (phase_reg == PH_ICM) && (c_reg != '0);
        v_dn = (phase_reg != PH_ML) && ((DIM_W'(r_reg) + DIM_W'(1)) < rows_eff);
        v_rt = (phase_reg != PH_ML) && ((DIM_W'(c_reg) + DIM_W'(1)) < cols_eff);
        n_valid = 3'(v_up) + 3'(v_dn) + 3'(v_lf) + 3'(v_rt);
        n_same  = 3'(v_up && nb_reg[1] == LAB_W'(cls_reg))
                + 3'(v_dn && nb_reg[2] == LAB_W'(cls_reg))
                + 3'(v_lf && nb_reg[3] == LAB_W'(cls_reg))
                + 3'(v_rt && nb_reg[4] == LAB_W'(cls_reg));
        pair_mult = $signed({3'b000, n_valid}) - $signed({2'b00, n_same, 1'b0});
        pair_term = PAIR_W'($signed({1'b0, beta_reg}) * pair_mult);
        off_cur   = off_tab[cls_reg];
        e_val = $signed({{(E_W-32){1'b0}}, mul_p[MUL_P_W-1:Q_W]})
              + $signed({{(E_W-Q_W){off_cur[Q_W-1]}}, off_cur})
              + $signed({{(E_W-PAIR_W){pair_term[PAIR_W-1]}}, pair_term});
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;

    logic              last_col, last_row, last_cls;
    logic signed [E_W-1:0] delta, delta_abs;
    logic [7:0]        passes_inc;

    assign last_col   = (DIM_W'(c_reg) + DIM_W'(1)) == cols_eff;
    assign last_row   = (DIM_W'(r_reg) + DIM_W'(1)) == rows_eff;
    assign last_cls   = (CCNT_W'(cls_reg) + CCNT_W'(1)) == ncls_eff;
    assign delta      = prev_reg - acc_reg;
    assign delta_abs  = delta[E_W-1] ? -delta : delta;
    assign passes_inc = passes_reg + 8'd1;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        first_tot_next  = first_tot_reg;
        first_eval_next = first_eval_reg;
        fj_next         = fj_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        cls_next        = cls_reg;
        lab_next        = lab_reg;
        pix_next        = pix_reg;
        nb_next         = nb_reg;
        best_next       = best_reg;
        acc_next        = acc_reg;
        prev_next       = prev_reg;
        passes_next     = passes_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_label_next  = out_label_reg;
        out_passes_next = out_passes_reg;
        out_conv_next   = out_conv_reg;
        out_energy_next = out_energy_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && in_op == OP_READ)
                begin
                    state_next = S_RDLAB;
                end
                else if (in_accept && in_op == OP_RUN)
                begin
                    state_next  = S_FETCH;
                    phase_next  = PH_ML;
                    fj_next     = '0;
                    r_next      = '0;
                    c_next      = '0;
                    passes_next = '0;
                end
            end
            S_RDLAB:
            begin
                // every 12-bit index lies inside the store
                out_valid_next  = 1'b1;
                out_kind_next   = KIND_READ;
                out_label_next  = lab_rd_reg;
                out_passes_next = '0;
                out_conv_next   = 1'b0;
                out_energy_next = '0;
                state_next      = S_IDLE;
            end
            S_FETCH:
            begin
                // data for the read issued last cycle
                if (fj_reg != 3'd0)
                begin
                    nb_next[fj_reg - 3'd1] = lab_rd_reg;
                end
                if (fj_reg == 3'd1)
                begin
                    pix_next = pix_rd_reg;
                end
                if (fj_reg == 3'd5)
                begin
                    state_next      = S_SQ;
                    first_eval_next = 1'b1;
                    cls_next        = (phase_reg == PH_ML) ? '0 : CLS_W'(nb_reg[0]);
                end
                else
                begin
                    fj_next = fj_reg + 3'd1;
                end
            end
            S_SQ:
            begin
                state_next = S_PROD;
            end
            S_PROD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_PIXEND;
                unique case (phase_reg)
                    PH_TOTAL:
                    begin
                        acc_next = acc_reg + e_val;
                    end
                    PH_ML:
                    begin
                        if (first_eval_reg || e_val < best_reg)
                        begin
                            best_next = e_val;
                            lab_next  = LAB_W'(cls_reg);
                        end
                        first_eval_next = 1'b0;
                        if (!last_cls)
                        begin
                            cls_next   = cls_reg + CLS_W'(1);
                            state_next = S_SQ;
                        end
                    end
                    default:
                    begin
                        // first visit scores the current label, then try every class
                        if (first_eval_reg)
                        begin
                            best_next       = e_val;
                            lab_next        = nb_reg[0];
                            first_eval_next = 1'b0;
                            cls_next        = '0;
                            state_next      = S_SQ;
                        end
                        else
                        begin
                            if (e_val < best_reg)
                            begin
                                best_next = e_val;
                                lab_next  = LAB_W'(cls_reg);
                            end
                            if (!last_cls)
                            begin
                                cls_next   = cls_reg + CLS_W'(1);
                                state_next = S_SQ;
                            end
                        end
                    end
                endcase
            end
            S_PIXEND:
            begin
                fj_next    = '0;
                state_next = S_FETCH;
                if (last_col)
                begin
                    c_next = '0;
                    if (last_row)
                    begin
                        r_next     = '0;
                        state_next = S_PASSEND;
                    end
                    else
                    begin
                        r_next = r_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    c_next = c_reg + COL_W'(1);
                end
            end
            S_PASSEND:
            begin
                state_next = S_FETCH;
                if (phase_reg != PH_TOTAL)
                begin
                    first_tot_next = (phase_reg == PH_ML);
                    phase_next     = PH_TOTAL;
                    acc_next       = '0;
                end
                else if (first_tot_reg)
                begin
                    prev_next  = acc_reg;
                    phase_next = PH_ICM;
                end
                else
                begin
                    prev_next   = acc_reg;
                    passes_next = passes_inc;
                    phase_next  = PH_ICM;
                    if (delta_abs <= $signed({{(E_W-32){1'b0}}, thr_reg})
                        || passes_inc >= limit_eff)
                    begin
                        state_next      = S_IDLE;
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_RUN;
                        out_label_next  = '0;
                        out_passes_next = passes_inc;
                        out_conv_next   = delta_abs <= $signed({{(E_W-32){1'b0}}, thr_reg});
                        out_energy_next = acc_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_ML;
            first_tot_reg <= 1'b0;
            fj_reg        <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            prev_reg      <= '0;
            passes_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            first_tot_reg <= first_tot_next;
            fj_reg        <= fj_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            prev_reg      <= prev_next;
            passes_reg    <= passes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_eval_reg <= first_eval_next;
        cls_reg        <= cls_next;
        lab_reg        <= lab_next;
        pix_reg        <= pix_next;
        nb_reg         <= nb_next;
        best_reg       <= best_next;
        acc_reg        <= acc_next;
        out_kind_reg   <= out_kind_next;
        out_label_reg  <= out_label_next;
        out_passes_reg <= out_passes_next;
        out_conv_reg   <= out_conv_next;
        out_energy_reg <= out_energy_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {4'b0, out_energy_reg, out_conv_reg, out_passes_reg, out_label_reg};

    // a result appears only at the end of a read or of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RDLAB || $past(state_reg) == S_PASSEND))
        else $error("result produced outside read or run completion");

    // a written label is always a class in use
    assert property (@(posedge clk) disable iff (!rst_n)
        lab_we |-> (CCNT_W'(lab_reg) < ncls_eff))
        else $error("label write outside the active class range");

    // a run never reports more passes than the bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_RUN) |-> (out_passes_reg <= limit_eff
            && out_passes_reg != 8'd0))
        else $error("pass count outside bound");

    // requests are taken only by an idle sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == S_IDLE))
        else $error("request accepted while busy");

endmodule

[hw/rtl/mrf_mul.sv]
// Shared registered unsigned multiplier used for the square and the scale steps.
module mrf_mul (
    input  logic                         clk,
    input  logic                         en,
    input  logic [mrf_pkg::MUL_A_W-1:0]  a,
    input  logic [mrf_pkg::Q_W-1:0]      b,
    output logic [mrf_pkg::MUL_P_W-1:0]  p
);
    import mrf_pkg::*;

    logic [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

    assign p = p_reg;

endmodule

[sim/mrf_icm_label_segmenter_tb.sv]
// Self-checking testbench for the MRF ICM label segmenter: streams, predicts, compares.
module mrf_icm_label_segmenter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrf_pkg::*;

    typedef struct {
        logic        kind;
        logic [2:0]  label;
        logic [7:0]  passes;
        logic        converged;
        logic [47:0] energy;
    } seg_result_t;

    // Segmentation predictor plus queue of results still owed by the block.
    class seg_scoreboard;
        bit [7:0]         pix[STORE_SIZE];
        bit [2:0]         lab[STORE_SIZE];
        bit [15:0]        mean[MAX_CLASSES];
        bit [15:0]        scale[MAX_CLASSES];
        bit signed [15:0] offs[MAX_CLASSES];
        bit [6:0]         rows_r = 7'd64;
        bit [6:0]         cols_r = 7'd64;
        bit [3:0]         ncls_r = 4'd2;
        bit [15:0]        beta_r = 16'd256;
        bit [31:0]        thresh_r = 32'd0;
        bit [7:0]         maxp_r = 8'd64;
        seg_result_t      owed[$];
        int               errors = 0;

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endtask

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_ROWS:   rows_r = val[6:0];
                REG_COLS:   cols_r = val[6:0];
                REG_CLASS:  ncls_r = val[3:0];
                REG_BETA:   beta_r = val[15:0];
                REG_THRESH: thresh_r = val;
                REG_PASSES: maxp_r = val[7:0];
                default: ;
            endcase
        endfunction

        function longint single(int p, int k);
            longint d;
            longint prod;
            d = longint'({pix[p], 8'h00}) - longint'(mean[k]);
            prod = d * d * longint'(scale[k]);
            return (prod >>> 16) + longint'(offs[k]);
        endfunction

        function longint pair(bit [2:0] a, bit [2:0] b);
            return (a == b) ? -longint'(beta_r) : longint'(beta_r);
        endfunction

        function longint local_e(int r, int c, int nr, int nc, bit [2:0] k);
            int p;
            longint e;
            p = r * MAX_COLS + c;
            e = single(p, k);
            if (r + 1 < nr) e += pair(k, lab[p + MAX_COLS]);
            if (c + 1 < nc) e += pair(k, lab[p + 1]);
            if (r > 0) e += pair(k, lab[p - MAX_COLS]);
            if (c > 0) e += pair(k, lab[p - 1]);
            return e;
        endfunction

        function longint total(int nr, int nc);
            longint e;
            int p;
            e = 0;
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++)
                begin
                    p = r * MAX_COLS + c;
                    e += single(p, lab[p]);
                    if (r + 1 < nr) e += pair(lab[p], lab[p + MAX_COLS]);
                    if (c + 1 < nc) e += pair(lab[p], lab[p + 1]);
                end
            if (e > 64'sh7FFF_FFFF_FFFF) e = 64'sh7FFF_FFFF_FFFF;
            if (e < -64'sh8000_0000_0000) e = -64'sh8000_0000_0000;
            return e;
        endfunction

        function seg_result_t segment();
            seg_result_t res;
            int nr, nc, nk, lim, p, passes;
            longint best, s, e, prev, delta;
            bit conv;
            nr = (rows_r == 0) ? 1 : (rows_r > MAX_ROWS ? MAX_ROWS : rows_r);
            nc = (cols_r == 0) ? 1 : (cols_r > MAX_COLS ? MAX_COLS : cols_r);
            nk = (ncls_r == 0) ? 1 : (ncls_r > MAX_CLASSES ? MAX_CLASSES : ncls_r);
            lim = (maxp_r == 0) ? 1 : maxp_r;
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++)
                begin
                    p = r * MAX_COLS + c;
                    best = single(p, 0);
                    lab[p] = 3'd0;
                    for (int k = 1; k < nk; k++)
                    begin
                        s = single(p, k);
                        if (s < best)
                        begin
                            best = s;
                            lab[p] = k[2:0];
                        end
                    end
                end
            prev = total(nr, nc);
            passes = 0;
            conv = 1'b0;
            forever
            begin
                for (int r = 0; r < nr; r++)
                    for (int c = 0; c < nc; c++)
                    begin
                        p = r * MAX_COLS + c;
                        for (int k = 0; k < nk; k++)
                            if (local_e(r, c, nr, nc, lab[p]) > local_e(r, c, nr, nc, k[2:0]))
                                lab[p] = k[2:0];
                    end
                e = total(nr, nc);
                delta = prev - e;
                if (delta < 0) delta = -delta;
                prev = e;
                passes++;
                if (delta <= longint'(thresh_r))
                begin
                    conv = 1'b1;
                    break;
                end
                if (passes >= lim) break;
            end
            res.kind = KIND_RUN;
            res.label = 3'd0;
            res.passes = passes[7:0];
            res.converged = conv;
            res.energy = e[47:0];
            return res;
        endfunction

        function void note_request(logic [1:0] op, logic [IN_DATA_W-1:0] d);
            seg_result_t res;
            int idx;
            idx = d[11:0];
            case (op)
                OP_LOAD:
                    if (idx < MAX_CLASSES)
                    begin
                        mean[idx] = d[35:20];
                        scale[idx] = d[51:36];
                        offs[idx] = d[67:52];
                    end
                OP_WRITE: pix[idx] = d[19:12];
                OP_RUN: owed.push_back(segment());
                default:
                begin
                    res.kind = KIND_READ;
                    res.label = lab[idx];
                    res.passes = 8'd0;
                    res.converged = 1'b0;
                    res.energy = 48'd0;
                    owed.push_back(res);
                end
            endcase
        endfunction

        task check_result(logic [OUT_DATA_W-1:0] d, logic kind);
            seg_result_t w;
            if (owed.size() == 0)
            begin
                report("unexpected result", d, 0);
                return;
            end
            w = owed.pop_front();
            if (kind !== w.kind) report("kind", kind, w.kind);
            if (d[2:0] !== w.label) report("label", d[2:0], w.label);
            if (d[10:3] !== w.passes) report("passes", d[10:3], w.passes);
            if (d[11] !== w.converged) report("converged", d[11], w.converged);
            if (d[59:12] !== w.energy) report("energy", d[59:12], w.energy);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = 3'd0;
    logic [31:0]           cfg_data = 32'd0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = 2'd0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    seg_scoreboard sb = new();
    bit  idle_on = 1'b1;
    bit  hold_long = 1'b0;
    int  sent = 0;
    bit  written[STORE_SIZE];
    bit  labeled[STORE_SIZE];
    bit  loaded[MAX_CLASSES];
    int  label_list[$];

    mrf_icm_label_segmenter dut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000_000;
        $display("[mrf_icm_label_segmenter] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack(int idx, int pv, int mn, int sc, int of);
        return {4'b0, of[15:0], sc[15:0], mn[15:0], pv[7:0], idx[11:0]};
    endfunction

    function automatic logic [IN_DATA_W-1:0] junk(int idx);
        return pack(idx, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic send(logic [1:0] op, logic [IN_DATA_W-1:0] d);
        bit rdy;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= op;
        do
        begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end while (!rdy);
        sent++;
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Drop valid and wait for every owed result, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (32) @(posedge clk);
    endtask

    task automatic configure(int nr, int nc, int nk, int beta, int th, int mp);
        set_reg(REG_ROWS, nr);
        set_reg(REG_COLS, nc);
        set_reg(REG_CLASS, nk);
        set_reg(REG_BETA, beta);
        set_reg(REG_THRESH, th);
        set_reg(REG_PASSES, mp);
        cfg_we <= 1'b0;
    endtask

    task automatic load_class(int k, int mn, int sc, int of);
        send(OP_LOAD, pack(k, $urandom, mn, sc, of));
        if (k < MAX_CLASSES) loaded[k] = 1'b1;
    endtask

    task automatic write_pixel(int p, int v);
        send(OP_WRITE, pack(p, v, $urandom, $urandom, $urandom));
        written[p] = 1'b1;
    endtask

    // Run over the configured region, marking its pixels as labeled.
    task automatic run_segment();
        int nr, nc, p;
        nr = (sb.rows_r == 0) ? 1 : (sb.rows_r > MAX_ROWS ? MAX_ROWS : sb.rows_r);
        nc = (sb.cols_r == 0) ? 1 : (sb.cols_r > MAX_COLS ? MAX_COLS : sb.cols_r);
        send(OP_RUN, junk($urandom));
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
            begin
                p = r * MAX_COLS + c;
                if (!labeled[p]) label_list.push_back(p);
                labeled[p] = 1'b1;
            end
    endtask

    task automatic read_label();
        send(OP_READ, junk(label_list[$urandom_range(0, label_list.size() - 1)]));
    endtask

    // One configuration, its loads and pixels, usually a run, and some label reads.
    task automatic segment_frame(bit pressure);
        int nr, nc, nk, er, ec, ek, beta, th, mp, p, nreads;
        case ($urandom_range(0, 9))
            0: begin nr = 64; nc = 1; end
            1: begin nr = 0; nc = $urandom_range(1, 64); end
            2: begin nr = 1; nc = 127; end
            default: begin nr = $urandom_range(1, 8); nc = $urandom_range(1, 8); end
        endcase
        nk = $urandom_range(0, 15);
        case ($urandom_range(0, 5))
            0: beta = 0;
            1: beta = 16'hFFFF;
            default: beta = $urandom_range(0, 1024);
        endcase
        case ($urandom_range(0, 5))
            0: th = 32'hFFFF_FFFF;
            1: th = $urandom;
            2: th = $urandom_range(1, 4096);
            default: th = 0;
        endcase
        mp = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 8);
        configure(nr, nc, nk, beta, th, mp);
        er = (nr == 0) ? 1 : (nr > MAX_ROWS ? MAX_ROWS : nr);
        ec = (nc == 0) ? 1 : (nc > MAX_COLS ? MAX_COLS : nc);
        ek = (nk == 0) ? 1 : (nk > MAX_CLASSES ? MAX_CLASSES : nk);
        for (int k = 0; k < MAX_CLASSES; k++)
            if ((k < ek && !loaded[k]) || $urandom_range(0, 3) == 0)
                load_class(k, $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0) load_class($urandom_range(MAX_CLASSES, 4095), 1, 2, 3);
        for (int r = 0; r < er; r++)
            for (int c = 0; c < ec; c++)
            begin
                p = r * MAX_COLS + c;
                if (!written[p] || $urandom_range(0, 1)) write_pixel(p, $urandom_range(0, 255));
            end
        if ($urandom_range(0, 3) == 0) write_pixel($urandom_range(0, 4095), $urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0) run_segment();
        if (pressure) hold_long = 1'b1;
        nreads = pressure ? 16 : $urandom_range(0, 8);
        if (label_list.size() != 0)
            repeat (nreads) read_label();
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 2x2 image, classes clamped to eight, single pass, extreme stats.
        configure(2, 2, 15, 16'hFFFF, 0, 0);
        load_class(0, 0, 0, 16'h8000);
        load_class(7, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        for (int k = 1; k < 7; k++) load_class(k, k * 9000, 16'h0100 << (k % 4), k * 500);
        load_class(8, 5, 5, 5);
        load_class(4095, 5, 5, 5);
        write_pixel(0, 0);
        write_pixel(1, 255);
        write_pixel(64, 128);
        write_pixel(65, 37);
        write_pixel(4095, 8'hAA);
        run_segment();
        send(OP_READ, junk(0));
        send(OP_READ, junk(1));
        send(OP_READ, junk(64));
        send(OP_READ, junk(65));
        drain();
        // Strongly smoothing prior, converges on threshold.
        configure(2, 2, 2, 16'h4000, 32'hFFFF_FFFF, 255);
        run_segment();
        drain();

        for (int f = 0; sent < 1350; f++)
        begin
            idle_on = (sent < 1150) && ($urandom_range(0, 4) != 0);
            segment_frame(f == 3);
        end
        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("[mrf_icm_label_segmenter] OK");
        else
            $display("[mrf_icm_label_segmenter] ERROR");
        $finish;
    end

endmodule
